// ----- src/dfs_pkg.sv -----
// Package for the delimited field selector: item types, queue entry,
// configuration bundle and shared constants. No dependencies.

package dfs_pkg;

  localparam int unsigned MaxFields    = 99;
  localparam int unsigned NoSelectFrom = 100;
  localparam int unsigned QueueDepth   = 4;
  localparam int unsigned FieldNumW    = 7;
  localparam int unsigned MaskHighW    = 35;
  localparam int unsigned MaskW        = 64 + MaskHighW;

  localparam logic [7:0]           NewlineByte      = 8'd10;
  localparam logic [7:0]           DefaultDelimiter = 8'd9;
  localparam logic [FieldNumW-1:0] FieldSat         = 7'd127;
  localparam logic [FieldNumW-1:0] FirstField       = 7'd1;

  typedef enum logic [1:0] {
    RegDelimiter = 2'd0,
    RegMaskLow   = 2'd1,
    RegMaskHigh  = 2'd2,
    RegUnused    = 2'd3
  } reg_index_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic       two_bytes;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
  } entry_t;

  typedef struct packed {
    logic [7:0]           delimiter;
    logic [63:0]          mask_low;
    logic [MaskHighW-1:0] mask_high;
  } cfg_t;

endpackage

// ----- src/delimited_field_selector.sv -----
// Top level of the delimited field selector: configuration registers,
// front part, request queue and back part. Depends on dfs_pkg and on
// dfs_front, dfs_queue and dfs_back.
//
// Usage: text bytes enter on the in channel (in_valid_i, in_data_i,
// in_stall_o); selected field bytes, separators and newlines leave on the
// out channel (out_valid_o, out_data_o, out_stall_i). An item is taken on a
// clock edge with valid high and stall low. Each input byte yields zero,
// one or two output bytes; last_of_run marks the final byte of an input.
// Throughput: one input byte and one output byte per cycle while the queue
// is not full and the output is not stalled. A byte that starts a selected
// field after an earlier printed field emits a separator and the byte; the
// request queue absorbs this. An accepted byte passes through the request
// queue and the output register before it shows at the output.
// in_stall_o rises only when the request queue is full, which happens when
// the receiver stalls or two-byte requests pile up. A stalled output holds.
// Reset clears line state, empties the queue and restores the delimiter to
// tab and both field masks to zero. The APB port writes registers at byte
// addresses 0 (delimiter), 8 (mask of fields 1-64), 16 (fields 65-99).

module delimited_field_selector
  import dfs_pkg::*;
#(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  input  in_item_t    in_data_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  output out_item_t   out_data_o,
  input  logic        out_stall_i
);

  cfg_t       cfg_q;
  reg_index_e reg_idx;
  logic       wr_en;
  logic       push;
  entry_t     push_data;
  logic       q_pop, q_valid, q_full;
  entry_t     q_head;

  assign pready  = 1'b1;
  assign reg_idx = reg_index_e'(paddr[4:3]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      RegDelimiter: prdata = {56'd0, cfg_q.delimiter};
      RegMaskLow:   prdata = cfg_q.mask_low;
      RegMaskHigh:  prdata = {{(64 - MaskHighW){1'b0}}, cfg_q.mask_high};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delimiter <= DefaultDelimiter;
      cfg_q.mask_low  <= '0;
      cfg_q.mask_high <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegDelimiter: cfg_q.delimiter <= pwdata[7:0];
        RegMaskLow:   cfg_q.mask_low  <= pwdata;
        RegMaskHigh:  cfg_q.mask_high <= pwdata[MaskHighW-1:0];
        default: begin
        end
      endcase
    end
  end

  dfs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  dfs_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head),
    .full_o      (q_full)
  );

  dfs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule

// ----- src/dfs_front.sv -----
// Front part of the field selector: accepts bytes, tracks line and field
// state and pushes one queue request per item that emits output.
// Depends on dfs_pkg.

module dfs_front
  import dfs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     in_valid_i,
  input  in_item_t in_data_i,
  output logic     in_stall_o,
  input  logic     q_full_i,
  output logic     push_o,
  output entry_t   push_data_o
);

  logic [FieldNumW-1:0] field_number_q, field_number_d;
  logic                 printed_any_q, printed_any_d;
  logic                 field_has_char_q, field_has_char_d;
  logic                 line_has_byte_q, line_has_byte_d;

  logic                 accept;
  logic                 selected;
  logic                 emit;
  logic [FieldNumW-1:0] sel_idx;
  logic [MaskW-1:0]     mask_all;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign mask_all   = {cfg_i.mask_high, cfg_i.mask_low};
  assign sel_idx    = field_number_q - FirstField;

  always_comb begin
    selected = 1'b0;
    if (field_number_q >= FirstField &&
        field_number_q <= FieldNumW'(MaxFields) &&
        field_number_q < FieldNumW'(NoSelectFrom) &&
        sel_idx < FieldNumW'(MaskW)) begin
      selected = mask_all[sel_idx];
    end
  end

  always_comb begin
    field_number_d   = field_number_q;
    printed_any_d    = printed_any_q;
    field_has_char_d = field_has_char_q;
    line_has_byte_d  = line_has_byte_q;
    emit             = 1'b0;
    push_data_o      = '{two_bytes: 1'b0, first_byte: NewlineByte,
                         second_byte: in_data_i.in_byte};
    if (in_data_i.end_of_input || in_data_i.in_byte == NewlineByte) begin
      emit             = in_data_i.end_of_input ? line_has_byte_q : 1'b1;
      field_number_d   = FirstField;
      printed_any_d    = 1'b0;
      field_has_char_d = 1'b0;
      line_has_byte_d  = 1'b0;
    end else if (in_data_i.in_byte == cfg_i.delimiter) begin
      if (selected && !field_has_char_q) begin
        emit          = printed_any_q;
        printed_any_d = 1'b1;
      end
      push_data_o.first_byte = cfg_i.delimiter;
      if (field_number_q < FieldSat) begin
        field_number_d = field_number_q + FirstField;
      end
      field_has_char_d = 1'b0;
      line_has_byte_d  = 1'b1;
    end else begin
      if (selected) begin
        emit                   = 1'b1;
        push_data_o.two_bytes  = !field_has_char_q && printed_any_q;
        push_data_o.first_byte = (!field_has_char_q && printed_any_q) ?
                                 cfg_i.delimiter : in_data_i.in_byte;
        printed_any_d          = 1'b1;
      end
      field_has_char_d = 1'b1;
      line_has_byte_d  = 1'b1;
    end
  end

  assign push_o = accept && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_number_q   <= FirstField;
      printed_any_q    <= 1'b0;
      field_has_char_q <= 1'b0;
      line_has_byte_q  <= 1'b0;
    end else if (accept) begin
      field_number_q   <= field_number_d;
      printed_any_q    <= printed_any_d;
      field_has_char_q <= field_has_char_d;
      line_has_byte_q  <= line_has_byte_d;
    end
  end

endmodule

// ----- src/dfs_queue.sv -----
// Short request queue between the front and back parts of the field
// selector. Depends on dfs_pkg for the entry type.

module dfs_queue
  import dfs_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_data_i,
  input  logic   pop_i,
  output logic   valid_o,
  output entry_t head_o,
  output logic   full_o
);

  localparam int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CountW = $clog2(Depth + 1);

  entry_t             mem_q [Depth];
  logic [AddrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CountW-1:0]  count_q, count_d;
  logic               do_pop;

  assign valid_o = count_q != '0;
  assign full_o  = count_q == CountW'(Depth);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    count_d = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + CountW'(1);
    end else if (do_pop && !push_i) begin
      count_d = count_q - CountW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + AddrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + AddrW'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !(push_i && !do_pop))
    else $error("queue push while full");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(Depth))
    else $error("queue count out of range");
`endif

endmodule

// ----- src/dfs_back.sv -----
// Back part of the field selector: drains queue requests into the output
// register, one byte per cycle while the output is not stalled, marking
// the last byte of each request. Depends on dfs_pkg.

module dfs_back
  import dfs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  entry_t    q_head_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  output out_item_t out_data_o,
  input  logic      out_stall_i
);

  logic      out_valid_q;
  out_item_t out_q, out_d;
  logic      phase_q, phase_d;
  logic      load;

  assign load = q_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    phase_d = phase_q;
    q_pop_o = 1'b0;
    out_d   = out_q;
    if (load) begin
      if (q_head_i.two_bytes && !phase_q) begin
        out_d   = '{out_byte: q_head_i.first_byte, last_of_run: 1'b0};
        phase_d = 1'b1;
      end else begin
        out_d   = '{out_byte: phase_q ? q_head_i.second_byte : q_head_i.first_byte,
                    last_of_run: 1'b1};
        phase_d = 1'b0;
        q_pop_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_phase_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> (q_valid_i && out_valid_q && !out_q.last_of_run))
    else $error("second byte pending without its request");
`endif

endmodule

// ----- sim/tb_delimited_field_selector.sv -----
// Testbench for delimited_field_selector: directed table plus random text lines,
// checked byte by byte against listed bytes or a field selection predictor.
// Depends on dfs_pkg and the delimited_field_selector RTL.
`timescale 1ns / 1ps

module tb_delimited_field_selector;
  import dfs_pkg::*;

  typedef enum logic {
    RowItem = 1'b0,
    RowCfg  = 1'b1
  } row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    reg_index_e idx;
    logic [63:0] value;
    in_item_t   item;
    logic       typed;
    logic [1:0] n;
    logic [7:0] b0;
    logic [7:0] b1;
  } script_row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [4:0]  paddr       = '0;
  logic [63:0] pwdata      = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid_i  = 1'b0;
  in_item_t    in_data_i   = '0;
  logic        in_stall_o;
  logic        out_valid_o;
  out_item_t   out_data_o;
  logic        out_stall_i = 1'b0;

  logic [7:0]           cut_delim;
  logic [63:0]          cut_mask_low;
  logic [MaskHighW-1:0] cut_mask_high;
  logic [FieldNumW-1:0] line_field;
  logic                 line_printed;
  logic                 field_started;
  logic                 line_open;

  out_item_t   selected_bytes_q [$];
  script_row_t script_q [$];
  int          mismatch_count = 0;
  int          items_sent     = 0;
  logic        idle_on        = 1'b1;
  logic        hold_pending   = 1'b0;
  logic        hold_started   = 1'b0;
  int          hold_left      = 0;

  delimited_field_selector i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .out_stall_i(out_stall_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("[delimited_field_selector] ERROR");
    $finish;
  end

  function automatic logic field_selected(input logic [FieldNumW-1:0] fn);
    if (fn < FirstField || fn >= NoSelectFrom || fn > MaxFields) return 1'b0;
    if (fn <= 64) return cut_mask_low[6'(fn - FirstField)];
    return cut_mask_high[6'(fn - 7'd65)];
  endfunction

  task automatic clear_line_state();
    line_field    = FirstField;
    line_printed  = 1'b0;
    field_started = 1'b0;
    line_open     = 1'b0;
  endtask

  task automatic select_fields(input in_item_t it, output int n,
                               output logic [7:0] b0, output logic [7:0] b1);
    logic [7:0] seq [0:1];
    logic       sel;
    n      = 0;
    seq[0] = '0;
    seq[1] = '0;
    sel    = field_selected(line_field);
    if (it.end_of_input) begin
      if (line_open) begin
        seq[n[0]] = NewlineByte;
        n++;
      end
      clear_line_state();
    end else if (it.in_byte == NewlineByte) begin
      seq[n[0]] = NewlineByte;
      n++;
      clear_line_state();
    end else if (it.in_byte == cut_delim) begin
      if (sel && !field_started) begin
        if (line_printed) begin
          seq[n[0]] = cut_delim;
          n++;
        end
        line_printed = 1'b1;
      end
      if (line_field < FieldSat) line_field = line_field + 1'b1;
      field_started = 1'b0;
      line_open     = 1'b1;
    end else begin
      if (sel) begin
        if (!field_started && line_printed) begin
          seq[n[0]] = cut_delim;
          n++;
        end
        seq[n[0]] = it.in_byte;
        n++;
        line_printed = 1'b1;
      end
      field_started = 1'b1;
      line_open     = 1'b1;
    end
    b0 = seq[0];
    b1 = seq[1];
  endtask

  task automatic queue_results(input int n, input logic [7:0] b0, input logic [7:0] b1);
    if (n >= 1) selected_bytes_q.push_back('{out_byte: b0, last_of_run: (n == 1)});
    if (n == 2) selected_bytes_q.push_back('{out_byte: b1, last_of_run: 1'b1});
  endtask

  task automatic send_request(input in_item_t it);
    idle_on = !(items_sent >= 300 && items_sent < 420);
    while (idle_on && $urandom_range(99) < 24) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    if (items_sent == 150) hold_pending = 1'b1;
  endtask

  task automatic feed(input in_item_t it);
    int         n;
    logic [7:0] b0;
    logic [7:0] b1;
    send_request(it);
    select_fields(it, n, b0, b1);
    queue_results(n, b0, b1);
  endtask

  task automatic wait_results_drained();
    int guard;
    guard = 0;
    while (selected_bytes_q.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    if (selected_bytes_q.size() != 0) begin
      $error("%0d expected bytes never arrived", selected_bytes_q.size());
      mismatch_count++;
      selected_bytes_q.delete();
    end
  endtask

  task automatic quiesce();
    in_valid_i <= 1'b0;
    wait_results_drained();
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_register(input reg_index_e idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      RegDelimiter: cut_delim     = value[7:0];
      RegMaskLow:   cut_mask_low  = value;
      RegMaskHigh:  cut_mask_high = value[MaskHighW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic add_cfg(input reg_index_e idx, input logic [63:0] value);
    script_q.push_back('{RowCfg, idx, value, 9'h0, 1'b0, 2'd0, 8'h0, 8'h0});
  endtask

  task automatic add_byte(input logic [7:0] b, input logic eoi);
    script_q.push_back('{RowItem, RegUnused, 64'h0, {b, eoi}, 1'b0, 2'd0, 8'h0, 8'h0});
  endtask

  task automatic add_check(input logic [7:0] b, input logic eoi, input logic [1:0] n,
                           input logic [7:0] b0, input logic [7:0] b1);
    script_q.push_back('{RowItem, RegUnused, 64'h0, {b, eoi}, 1'b1, n, b0, b1});
  endtask

  task automatic run_script();
    script_row_t row;
    int          n;
    logic [7:0]  b0;
    logic [7:0]  b1;
    foreach (script_q[i]) begin
      row = script_q[i];
      if (row.kind == RowCfg) begin
        quiesce();
        write_register(row.idx, row.value);
      end else begin
        send_request(row.item);
        select_fields(row.item, n, b0, b1);
        if (row.typed) queue_results(row.n, row.b0, row.b1);
        else queue_results(n, b0, b1);
      end
    end
  endtask

  function automatic logic [7:0] pick_text_byte();
    logic [7:0] b;
    if ($urandom_range(19) == 0) return 8'($urandom_range(255));
    do b = 8'($urandom_range(255)); while (b == cut_delim || b == NewlineByte);
    return b;
  endfunction

  task automatic send_line(input int nf, input logic long_line);
    int len;
    int r;
    for (int f = 0; f < nf; f++) begin
      if (f > 0) feed('{in_byte: cut_delim, end_of_input: 1'b0});
      len = long_line ? ($urandom_range(9) == 0) : $urandom_range(4);
      for (int c = 0; c < len; c++) feed('{in_byte: pick_text_byte(), end_of_input: 1'b0});
    end
    r = $urandom_range(99);
    if (r < 82) feed('{in_byte: NewlineByte, end_of_input: 1'b0});
    else if (r < 94) feed('{in_byte: 8'($urandom_range(255)), end_of_input: 1'b1});
  endtask

  task automatic configure_phase(input int phase);
    logic [7:0]  delim;
    logic [63:0] low;
    logic [63:0] high;
    int          r;
    quiesce();
    r = $urandom_range(5);
    case (phase)
      0: delim = 8'd9;
      1: delim = 8'd255;
      2: delim = 8'd0;
      3: delim = NewlineByte;
      default: delim = (r == 0) ? 8'd44 : (r == 1) ? 8'd9 : 8'($urandom_range(255));
    endcase
    r = $urandom_range(7);
    if (phase == 0 || (phase > 3 && r < 2)) begin
      low  = '1;
      high = '1;
    end else if (phase == 1 || (phase > 3 && r == 2)) begin
      low  = '0;
      high = '0;
    end else begin
      low  = {$urandom, $urandom};
      high = {$urandom, $urandom};
    end
    write_register(RegDelimiter, 64'(delim));
    write_register(RegMaskLow, low);
    write_register(RegMaskHigh, high);
    if ($urandom_range(3) == 0) write_register(RegUnused, {$urandom, $urandom});
  endtask

  always @(posedge clk_i) begin
    if (hold_pending && !hold_started) begin
      hold_started = 1'b1;
      hold_left    = 200;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= idle_on && ($urandom_range(99) < 24);
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (selected_bytes_q.size() == 0) begin
        $error("unexpected output byte %0h", out_data_o.out_byte);
        mismatch_count++;
      end else begin
        want = selected_bytes_q.pop_front();
        if (out_data_o.out_byte !== want.out_byte) begin
          $error("out_byte: expected %0h, got %0h", want.out_byte, out_data_o.out_byte);
          mismatch_count++;
        end
        if (out_data_o.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %0b, got %0b",
                 want.last_of_run, out_data_o.last_of_run);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int phase;
    int phase_end;
    cut_delim     = DefaultDelimiter;
    cut_mask_low  = '0;
    cut_mask_high = '0;
    clear_line_state();

    add_check(8'h61, 1'b0, 2'd0, 8'h00, 8'h00);
    add_check(8'd9, 1'b0, 2'd0, 8'h00, 8'h00);
    add_check(NewlineByte, 1'b0, 2'd1, NewlineByte, 8'h00);
    add_cfg(RegDelimiter, 64'd44);
    add_cfg(RegMaskLow, 64'h5);
    add_cfg(RegMaskHigh, 64'h4_0000_0000);
    add_cfg(RegUnused, 64'hFFFF_FFFF_FFFF_FFFF);
    add_check(8'h61, 1'b0, 2'd1, 8'h61, 8'h00);
    add_check(8'd44, 1'b0, 2'd0, 8'h00, 8'h00);
    add_check(8'd44, 1'b0, 2'd0, 8'h00, 8'h00);
    add_check(8'h78, 1'b0, 2'd2, 8'd44, 8'h78);
    add_check(NewlineByte, 1'b0, 2'd1, NewlineByte, 8'h00);
    add_check(8'd44, 1'b0, 2'd0, 8'h00, 8'h00);
    add_check(8'd44, 1'b0, 2'd0, 8'h00, 8'h00);
    add_check(8'd44, 1'b0, 2'd1, 8'd44, 8'h00);
    add_check(8'hFF, 1'b0, 2'd0, 8'h00, 8'h00);
    add_check(8'hAA, 1'b1, 2'd1, NewlineByte, 8'h00);
    add_check(8'h00, 1'b1, 2'd0, 8'h00, 8'h00);
    add_check(8'h00, 1'b0, 2'd1, 8'h00, 8'h00);
    add_byte(8'h62, 1'b0);
    add_byte(8'd44, 1'b0);
    add_byte(8'd44, 1'b0);
    add_byte(8'h63, 1'b0);
    add_check(NewlineByte, 1'b1, 2'd1, NewlineByte, 8'h00);
    add_check(NewlineByte, 1'b0, 2'd1, NewlineByte, 8'h00);
    add_cfg(RegDelimiter, 64'(NewlineByte));
    add_cfg(RegMaskLow, 64'hFFFF_FFFF_FFFF_FFFF);
    add_check(8'h71, 1'b0, 2'd1, 8'h71, 8'h00);
    add_check(NewlineByte, 1'b0, 2'd1, NewlineByte, 8'h00);
    add_cfg(RegDelimiter, 64'd0);
    add_cfg(RegMaskLow, 64'h2);
    add_check(8'h00, 1'b0, 2'd0, 8'h00, 8'h00);
    add_check(8'h7A, 1'b0, 2'd1, 8'h7A, 8'h00);
    add_check(8'h00, 1'b0, 2'd0, 8'h00, 8'h00);
    add_check(8'h80, 1'b0, 2'd0, 8'h00, 8'h00);
    add_check(NewlineByte, 1'b0, 2'd1, NewlineByte, 8'h00);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_script();

    phase = 0;
    while (items_sent < 680) begin
      configure_phase(phase);
      if (phase == 0) send_line(128, 1'b1);
      phase_end = items_sent + 60 + $urandom_range(40);
      while (items_sent < phase_end) begin
        if ($urandom_range(19) == 0) send_line($urandom_range(95, 130), 1'b1);
        else send_line($urandom_range(1, 6), 1'b0);
        if ($urandom_range(29) == 0) begin
          feed('{in_byte: 8'($urandom_range(255)), end_of_input: 1'b1});
        end
      end
      phase++;
    end

    in_valid_i <= 1'b0;
    wait_results_drained();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[delimited_field_selector] OK");
    end else begin
      $display("[delimited_field_selector] ERROR");
    end
    $finish;
  end

endmodule

// ----- delimited_field_selector.f -----
src/dfs_pkg.sv
src/dfs_front.sv
src/dfs_queue.sv
src/dfs_back.sv
src/delimited_field_selector.sv
sim/tb_delimited_field_selector.sv
